// File: sv/csts_pkg.sv
// ----------------------------------------------------------------------------
// csts_pkg
// Widths, stage counts and types shared by the cubic trajectory step pipeline.
// ----------------------------------------------------------------------------
package csts_pkg;

    localparam int NW           = 147;
    localparam int DW           = 112;
    localparam int QBITS        = 31;
    localparam int FRONT_STAGES = 11;
    localparam int DIV_STAGES   = QBITS + 1;
    localparam int NSTAGE       = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [15:0] TIME_STEP_RESET = 16'd655;
    localparam logic [31:0] SAT_POS         = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG         = 32'h8000_0000;

    typedef logic signed [NW-1:0] num_t;
    typedef logic        [DW-1:0] den_t;
    typedef logic signed [31:0]   word_t;

endpackage

// File: sv/csts_if.sv
// ----------------------------------------------------------------------------
// csts_in_if / csts_out_if
// Valid/ready channels for joint state beats and trajectory result beats.
// ----------------------------------------------------------------------------
interface csts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] current_position;
    logic signed [31:0] current_velocity;
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic        [31:0] time_remaining;

    modport source (
        output valid, current_position, current_velocity, target_position,
               target_velocity, time_remaining,
        input  ready
    );
    modport sink (
        input  valid, current_position, current_velocity, target_position,
               target_velocity, time_remaining,
        output ready
    );
endinterface

interface csts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_position;
    logic signed [31:0] next_velocity;
    logic signed [31:0] next_acceleration;
    logic               divide_fault;

    modport source (
        output valid, next_position, next_velocity, next_acceleration, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, next_position, next_velocity, next_acceleration, divide_fault,
        output ready
    );
endinterface

// File: sv/csts_wmul.sv
// ----------------------------------------------------------------------------
// csts_wmul
// Signed 128 x unsigned 32 multiply in two stages: limb products, then sum.
// ----------------------------------------------------------------------------
module csts_wmul import csts_pkg::*; (
    input  logic                clk,
    input  logic                en1,
    input  logic                en2,
    input  logic signed [127:0] a,
    input  logic        [31:0]  b,
    output logic signed [159:0] p
);

    logic        [63:0] pp0_reg, pp1_reg, pp2_reg;
    logic signed [64:0] pp3_reg;
    logic signed [64:0] pp3_next;
    logic        [159:0] p_next;

    assign pp3_next = $signed(a[127:96]) * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pp0_reg <= 64'(a[31:0])  * 64'(b);
            pp1_reg <= 64'(a[63:32]) * 64'(b);
            pp2_reg <= 64'(a[95:64]) * 64'(b);
            pp3_reg <= pp3_next;
        end
    end

    assign p_next = {pp3_reg[63:0], 96'b0} + {32'b0, pp2_reg, 64'b0}
                  + {64'b0, pp1_reg, 32'b0} + {96'b0, pp0_reg};

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            p <= $signed(p_next);
        end
    end

endmodule

// File: sv/csts_front.sv
// ----------------------------------------------------------------------------
// csts_front
// Builds the exact numerators and T^3 for position, velocity, acceleration.
// ----------------------------------------------------------------------------
module csts_front import csts_pkg::*; (
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] en,
    input  logic signed [31:0]      cur_pos,
    input  logic signed [31:0]      cur_vel,
    input  logic signed [31:0]      tgt_pos,
    input  logic signed [31:0]      tgt_vel,
    input  logic        [31:0]      t_rem,
    input  logic        [15:0]      dt,
    output num_t                    pos_num,
    output num_t                    vel_num,
    output num_t                    acc_num,
    output logic        [95:0]      t3_out,
    output logic signed [31:0]      x_out,
    output logic                    flt_out
);

    // stage 1
    logic signed [31:0] x_s1_reg, xd_s1_reg;
    logic signed [32:0] d_s1_reg, b_s1_reg;
    logic signed [33:0] a_s1_reg;
    logic        [31:0] t_s1_reg;
    logic        [15:0] s_s1_reg;
    logic               flt_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_s1_reg   <= cur_pos;
            xd_s1_reg  <= cur_vel;
            d_s1_reg   <= {tgt_pos[31], tgt_pos} - {cur_pos[31], cur_pos};
            a_s1_reg   <= {{2{tgt_vel[31]}}, tgt_vel} + {cur_vel[31], cur_vel, 1'b0};
            b_s1_reg   <= {tgt_vel[31], tgt_vel} + {cur_vel[31], cur_vel};
            t_s1_reg   <= t_rem;
            s_s1_reg   <= dt;
            flt_s1_reg <= (t_rem == 32'd0);
        end
    end

    // stages 2-3: T^2, a*T, b*T, xd*T, x*T
    logic signed [159:0] p_tt, p_at, p_bt, p_xdt, p_xt;

    csts_wmul u_tt  (.clk(clk), .en1(en[1]), .en2(en[2]),
                     .a($signed({96'b0, t_s1_reg})), .b(t_s1_reg), .p(p_tt));
    csts_wmul u_at  (.clk(clk), .en1(en[1]), .en2(en[2]),
                     .a({{94{a_s1_reg[33]}}, a_s1_reg}), .b(t_s1_reg), .p(p_at));
    csts_wmul u_bt  (.clk(clk), .en1(en[1]), .en2(en[2]),
                     .a({{95{b_s1_reg[32]}}, b_s1_reg}), .b(t_s1_reg), .p(p_bt));
    csts_wmul u_xdt (.clk(clk), .en1(en[1]), .en2(en[2]),
                     .a({{96{xd_s1_reg[31]}}, xd_s1_reg}), .b(t_s1_reg), .p(p_xdt));
    csts_wmul u_xt  (.clk(clk), .en1(en[1]), .en2(en[2]),
                     .a({{96{x_s1_reg[31]}}, x_s1_reg}), .b(t_s1_reg), .p(p_xt));

    logic signed [32:0] d_s2_reg, d_s3_reg;
    logic        [31:0] t_s2_reg, t_s3_reg;
    logic        [15:0] s_s2_reg, s_s3_reg;
    logic signed [31:0] x_s2_reg, x_s3_reg;
    logic               flt_s2_reg, flt_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d_s2_reg   <= d_s1_reg;
            t_s2_reg   <= t_s1_reg;
            s_s2_reg   <= s_s1_reg;
            x_s2_reg   <= x_s1_reg;
            flt_s2_reg <= flt_s1_reg;
        end
        if (en[2])
        begin
            d_s3_reg   <= d_s2_reg;
            t_s3_reg   <= t_s2_reg;
            s_s3_reg   <= s_s2_reg;
            x_s3_reg   <= x_s2_reg;
            flt_s3_reg <= flt_s2_reg;
        end
    end

    // stage 4: pn = 3*D*2^16 - a*T, qn = b*T - 2*D*2^16
    logic signed [34:0] d3x;
    logic signed [67:0] pn_next;
    logic signed [66:0] qn_next;

    assign d3x     = {{2{d_s3_reg[32]}}, d_s3_reg} + {d_s3_reg[32], d_s3_reg, 1'b0};
    assign pn_next = {{17{d3x[34]}}, d3x, 16'b0} - {{2{p_at[65]}}, p_at[65:0]};
    assign qn_next = {{2{p_bt[64]}}, p_bt[64:0]} - {{17{d_s3_reg[32]}}, d_s3_reg, 17'b0};

    logic signed [67:0] pn_s4_reg;
    logic signed [66:0] qn_s4_reg;
    logic        [63:0] tt_s4_reg;
    logic signed [63:0] xdt_s4_reg, xt_s4_reg;
    logic        [31:0] t_s4_reg, s2_s4_reg;
    logic        [15:0] s_s4_reg;
    logic signed [31:0] x_s4_reg;
    logic               flt_s4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pn_s4_reg  <= pn_next;
            qn_s4_reg  <= qn_next;
            tt_s4_reg  <= p_tt[63:0];
            xdt_s4_reg <= p_xdt[63:0];
            xt_s4_reg  <= p_xt[63:0];
            t_s4_reg   <= t_s3_reg;
            s_s4_reg   <= s_s3_reg;
            s2_s4_reg  <= 32'(s_s3_reg) * 32'(s_s3_reg);
            x_s4_reg   <= x_s3_reg;
            flt_s4_reg <= flt_s3_reg;
        end
    end

    // stages 5-6: T^3, xd*T^2, x*T^2, pn*T, qn*s
    logic signed [159:0] p_t3, p_xdt2, p_xt2, p_pt, p_qs;

    csts_wmul u_t3   (.clk(clk), .en1(en[4]), .en2(en[5]),
                      .a($signed({64'b0, tt_s4_reg})), .b(t_s4_reg), .p(p_t3));
    csts_wmul u_xdt2 (.clk(clk), .en1(en[4]), .en2(en[5]),
                      .a({{64{xdt_s4_reg[63]}}, xdt_s4_reg}), .b(t_s4_reg), .p(p_xdt2));
    csts_wmul u_xt2  (.clk(clk), .en1(en[4]), .en2(en[5]),
                      .a({{64{xt_s4_reg[63]}}, xt_s4_reg}), .b(t_s4_reg), .p(p_xt2));
    csts_wmul u_pt   (.clk(clk), .en1(en[4]), .en2(en[5]),
                      .a({{60{pn_s4_reg[67]}}, pn_s4_reg}), .b(t_s4_reg), .p(p_pt));
    csts_wmul u_qs   (.clk(clk), .en1(en[4]), .en2(en[5]),
                      .a({{61{qn_s4_reg[66]}}, qn_s4_reg}), .b({16'b0, s_s4_reg}),
                      .p(p_qs));

    logic [31:0]        t_s5_reg, t_s6_reg, s2_s5_reg, s2_s6_reg;
    logic [15:0]        s_s5_reg, s_s6_reg;
    logic signed [31:0] x_s5_reg, x_s6_reg;
    logic               flt_s5_reg, flt_s6_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            t_s5_reg   <= t_s4_reg;
            s_s5_reg   <= s_s4_reg;
            s2_s5_reg  <= s2_s4_reg;
            x_s5_reg   <= x_s4_reg;
            flt_s5_reg <= flt_s4_reg;
        end
        if (en[5])
        begin
            t_s6_reg   <= t_s5_reg;
            s_s6_reg   <= s_s5_reg;
            s2_s6_reg  <= s2_s5_reg;
            x_s6_reg   <= x_s5_reg;
            flt_s6_reg <= flt_s5_reg;
        end
    end

    // stage 7: g, e, f; stages 7-8: xd*T^3, x*T^3
    logic signed [102:0] pt_w, qs_w;

    assign pt_w = {{3{p_pt[99]}}, p_pt[99:0]};
    assign qs_w = {{20{p_qs[82]}}, p_qs[82:0]};

    logic signed [159:0] p_xdt3, p_xt3;

    csts_wmul u_xdt3 (.clk(clk), .en1(en[6]), .en2(en[7]),
                      .a({{32{p_xdt2[95]}}, p_xdt2[95:0]}), .b(t_s6_reg), .p(p_xdt3));
    csts_wmul u_xt3  (.clk(clk), .en1(en[6]), .en2(en[7]),
                      .a({{32{p_xt2[95]}}, p_xt2[95:0]}), .b(t_s6_reg), .p(p_xt3));

    logic signed [102:0] g_s7_reg, e_s7_reg, f_s7_reg, g_s8_reg, e_s8_reg, f_s8_reg;
    logic        [95:0]  t3_s7_reg, t3_s8_reg;
    logic        [15:0]  s_s7_reg, s_s8_reg;
    logic        [31:0]  s2_s7_reg, s2_s8_reg;
    logic signed [31:0]  x_s7_reg, x_s8_reg;
    logic                flt_s7_reg, flt_s8_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            g_s7_reg   <= pt_w + qs_w;
            e_s7_reg   <= (pt_w <<< 1) + qs_w + (qs_w <<< 1);
            f_s7_reg   <= (pt_w <<< 1) + (qs_w <<< 2) + (qs_w <<< 1);
            t3_s7_reg  <= p_t3[95:0];
            s_s7_reg   <= s_s6_reg;
            s2_s7_reg  <= s2_s6_reg;
            x_s7_reg   <= x_s6_reg;
            flt_s7_reg <= flt_s6_reg;
        end
        if (en[7])
        begin
            g_s8_reg   <= g_s7_reg;
            e_s8_reg   <= e_s7_reg;
            f_s8_reg   <= f_s7_reg;
            t3_s8_reg  <= t3_s7_reg;
            s_s8_reg   <= s_s7_reg;
            s2_s8_reg  <= s2_s7_reg;
            x_s8_reg   <= x_s7_reg;
            flt_s8_reg <= flt_s7_reg;
        end
    end

    // stages 9-10: s*xd*T^3, s^2*g, s*e
    logic signed [159:0] p_sxd, p_s2g, p_se;

    csts_wmul u_sxd (.clk(clk), .en1(en[8]), .en2(en[9]),
                     .a(p_xdt3[127:0]), .b({16'b0, s_s8_reg}), .p(p_sxd));
    csts_wmul u_s2g (.clk(clk), .en1(en[8]), .en2(en[9]),
                     .a({{25{g_s8_reg[102]}}, g_s8_reg}), .b(s2_s8_reg), .p(p_s2g));
    csts_wmul u_se  (.clk(clk), .en1(en[8]), .en2(en[9]),
                     .a({{25{e_s8_reg[102]}}, e_s8_reg}), .b({16'b0, s_s8_reg}),
                     .p(p_se));

    logic signed [127:0] xdt3_s9_reg, xdt3_s10_reg, xt3_s9_reg, xt3_s10_reg;
    logic signed [102:0] f_s9_reg, f_s10_reg;
    logic        [95:0]  t3_s9_reg, t3_s10_reg;
    logic signed [31:0]  x_s9_reg, x_s10_reg;
    logic                flt_s9_reg, flt_s10_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            xdt3_s9_reg <= p_xdt3[127:0];
            xt3_s9_reg  <= p_xt3[127:0];
            f_s9_reg    <= f_s8_reg;
            t3_s9_reg   <= t3_s8_reg;
            x_s9_reg    <= x_s8_reg;
            flt_s9_reg  <= flt_s8_reg;
        end
        if (en[9])
        begin
            xdt3_s10_reg <= xdt3_s9_reg;
            xt3_s10_reg  <= xt3_s9_reg;
            f_s10_reg    <= f_s9_reg;
            t3_s10_reg   <= t3_s9_reg;
            x_s10_reg    <= x_s9_reg;
            flt_s10_reg  <= flt_s9_reg;
        end
    end

    // stage 11: final numerators
    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            pos_num <= p_sxd[NW-1:0] + p_s2g[NW-1:0]
                     + {{3{xt3_s10_reg[127]}}, xt3_s10_reg, 16'b0};
            vel_num <= {{19{xdt3_s10_reg[127]}}, xdt3_s10_reg} + p_se[NW-1:0];
            acc_num <= {{28{f_s10_reg[102]}}, f_s10_reg, 16'b0};
            t3_out  <= t3_s10_reg;
            x_out   <= x_s10_reg;
            flt_out <= flt_s10_reg;
        end
    end

endmodule

// File: sv/csts_div.sv
// ----------------------------------------------------------------------------
// csts_div
// Pipelined restoring divider: range check stage, then one quotient bit per stage; int32 saturation.
// ----------------------------------------------------------------------------
module csts_div import csts_pkg::*; (
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  num_t                  num,
    input  den_t                  den,
    output word_t                 quo
);

    logic [NW-1:0]    rem_reg [DIV_STAGES];
    den_t             den_reg [DIV_STAGES];
    logic [QBITS-1:0] q_reg   [DIV_STAGES];
    logic             neg_reg [DIV_STAGES];
    logic             sat_reg [DIV_STAGES];

    logic [NW-1:0] mag;
    logic [NW-1:0] lim;

    assign mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign lim = {{(NW-DW-QBITS){1'b0}}, den, {QBITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= mag;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1];
            sat_reg[0] <= (mag >= lim);
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_step
        localparam int SH = DIV_STAGES - 1 - j;
        logic [NW-1:0] sub;
        logic          ge;

        assign sub = {{(NW-DW){1'b0}}, den_reg[j-1]} << SH;
        assign ge  = (rem_reg[j-1] >= sub);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? rem_reg[j-1] - sub : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (ge ? (QBITS'(1) << SH) : '0);
                neg_reg[j] <= neg_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    logic [31:0] qz;

    assign qz = {1'b0, q_reg[DIV_STAGES-1]};

    always_comb
    begin
        if (sat_reg[DIV_STAGES-1])
        begin
            quo = neg_reg[DIV_STAGES-1] ? $signed(SAT_NEG) : $signed(SAT_POS);
        end
        else
        begin
            quo = neg_reg[DIV_STAGES-1] ? $signed(-qz) : $signed(qz);
        end
    end

endmodule

// File: sv/cubic_spline_trajectory_step.sv
// ----------------------------------------------------------------------------
// cubic_spline_trajectory_step
// Fits a cubic to the present and goal joint state and steps it by dt.
//
//   port          dir   kind        content
//   item          in    valid/ready joint position/velocity, goal, time to go
//   result        out   valid/ready next position/velocity/accel, fault flag
//   cfg_wr_en/da  in    write       time_step (dt), takes effect on next beat
//
// One beat per cycle sustained unless result stalls; 11 numerator stages built
// from two-stage 128x32 limb multipliers, a 32-stage restoring divider (a range
// check stage, then one quotient bit per stage), one output register.
// Reset clears all stage valids and loads time_step with 655.
// A stall on result backs up only into full stages; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module cubic_spline_trajectory_step import csts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    csts_in_if.sink     item,
    csts_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0]       time_step_reg;
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            time_step_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || result.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= item.valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign item.ready = rdy[0];

    num_t               pos_num, vel_num, acc_num;
    logic [95:0]        t3;
    logic signed [31:0] x_f;
    logic               flt_f;

    csts_front u_front (
        .clk     (clk),
        .en      (rdy[FRONT_STAGES-1:0]),
        .cur_pos (item.current_position),
        .cur_vel (item.current_velocity),
        .tgt_pos (item.target_position),
        .tgt_vel (item.target_velocity),
        .t_rem   (item.time_remaining),
        .dt      (time_step_reg),
        .pos_num (pos_num),
        .vel_num (vel_num),
        .acc_num (acc_num),
        .t3_out  (t3),
        .x_out   (x_f),
        .flt_out (flt_f)
    );

    logic [DIV_STAGES-1:0] den_en;
    word_t                 pos_q, vel_q, acc_q;

    assign den_en = rdy[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES];

    csts_div u_div_pos (.clk(clk), .en(den_en), .num(pos_num),
                        .den({t3, 16'b0}), .quo(pos_q));
    csts_div u_div_vel (.clk(clk), .en(den_en), .num(vel_num),
                        .den({16'b0, t3}), .quo(vel_q));
    csts_div u_div_acc (.clk(clk), .en(den_en), .num(acc_num),
                        .den({16'b0, t3}), .quo(acc_q));

    logic signed [31:0] x_tag_reg   [DIV_STAGES];
    logic               flt_tag_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (den_en[0])
        begin
            x_tag_reg[0]   <= x_f;
            flt_tag_reg[0] <= flt_f;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (den_en[k])
            begin
                x_tag_reg[k]   <= x_tag_reg[k-1];
                flt_tag_reg[k] <= flt_tag_reg[k-1];
            end
        end
    end

    word_t pos_reg, vel_reg, acc_reg;
    logic  flt_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[NSTAGE-1])
        begin
            flt_reg <= flt_tag_reg[DIV_STAGES-1];
            pos_reg <= flt_tag_reg[DIV_STAGES-1] ? x_tag_reg[DIV_STAGES-1] : pos_q;
            vel_reg <= flt_tag_reg[DIV_STAGES-1] ? '0 : vel_q;
            acc_reg <= flt_tag_reg[DIV_STAGES-1] ? '0 : acc_q;
        end
    end

    assign result.valid             = v_reg[NSTAGE-1];
    assign result.next_position     = pos_reg;
    assign result.next_velocity     = vel_reg;
    assign result.next_acceleration = acc_reg;
    assign result.divide_fault      = flt_reg;

    a_beats_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        !(item.valid && item.ready) && !(result.valid && result.ready)
        |=> $countones(v_reg) == $past($countones(v_reg)))
        else $error("pipeline beat count changed without a handshake");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (&v_reg))
        else $error("input stalled while a stage is empty");

    a_fault_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.divide_fault
        |-> result.next_velocity == 0 && result.next_acceleration == 0)
        else $error("fault beat carries nonzero velocity or acceleration");

endmodule
